// ----- rtl/ddo_pkg.sv -----
// Shared types, constants and the arctangent table of the odometry block.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;

  typedef enum logic [2:0] {
    MUL_IDLE       = 3'd0,
    MUL_SUM_DPC    = 3'd1,
    MUL_DIF_DPC    = 3'd2,
    MUL_DISP_K     = 3'd3,
    MUL_DIFLO_GAIN = 3'd4,
    MUL_DIFHI_GAIN = 3'd5
  } mul_sel_t;

  typedef enum logic [3:0] {
    CAP_NONE   = 4'd0,
    CAP_DISP   = 4'd1,
    CAP_DIF    = 4'd2,
    CAP_VINIT  = 4'd3,
    CAP_DTH_LO = 4'd4,
    CAP_DTH_HI = 4'd5,
    CAP_CORDIC = 4'd6,
    CAP_ROTATE = 4'd7,
    CAP_LATCH  = 4'd8,
    CAP_EMIT   = 4'd9
  } cap_t;

  typedef enum logic [2:0] {
    BR_NEXT  = 3'd0,
    BR_LATCH = 3'd1,
    BR_ITER  = 3'd2,
    BR_JUMP  = 3'd3,
    BR_END   = 3'd4
  } br_t;

  typedef logic [3:0] pc_t;

  typedef struct packed {
    mul_sel_t mul;
    cap_t     cap;
    br_t      br;
    pc_t      target;
  } uword_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul;
    cap_t     cap;
  } ctl_t;

  typedef struct packed {
    logic latch;
    logic iter_last;
  } status_t;

  function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/ddo_sequencer.sv -----
// Microcode ROM, step counter and stream handshake control of the odometry block.
`timescale 1ns / 1ps
module ddo_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  ddo_pkg::status_t st,
  output ddo_pkg::ctl_t    ctl
);
  import ddo_pkg::*;

  localparam pc_t S_SUM    = 4'd0;
  localparam pc_t S_DIF    = 4'd1;
  localparam pc_t S_DISPK  = 4'd2;
  localparam pc_t S_GLO    = 4'd3;
  localparam pc_t S_GHI    = 4'd4;
  localparam pc_t S_DTH    = 4'd5;
  localparam pc_t S_CORDIC = 4'd6;
  localparam pc_t S_ROT    = 4'd7;
  localparam pc_t S_EMIT   = 4'd8;
  localparam pc_t S_LATCH  = 4'd9;

  logic   busy;
  pc_t    pc;
  uword_t word;
  logic   stall;
  logic   run;

  always_comb begin
    case (pc)
      S_SUM:    word = '{MUL_SUM_DPC,    CAP_NONE,   BR_LATCH, S_LATCH};
      S_DIF:    word = '{MUL_DIF_DPC,    CAP_DISP,   BR_NEXT,  S_SUM};
      S_DISPK:  word = '{MUL_DISP_K,     CAP_DIF,    BR_NEXT,  S_SUM};
      S_GLO:    word = '{MUL_DIFLO_GAIN, CAP_VINIT,  BR_NEXT,  S_SUM};
      S_GHI:    word = '{MUL_DIFHI_GAIN, CAP_DTH_LO, BR_NEXT,  S_SUM};
      S_DTH:    word = '{MUL_IDLE,       CAP_DTH_HI, BR_NEXT,  S_SUM};
      S_CORDIC: word = '{MUL_IDLE,       CAP_CORDIC, BR_ITER,  S_CORDIC};
      S_ROT:    word = '{MUL_IDLE,       CAP_ROTATE, BR_NEXT,  S_SUM};
      S_EMIT:   word = '{MUL_IDLE,       CAP_EMIT,   BR_END,   S_SUM};
      S_LATCH:  word = '{MUL_IDLE,       CAP_LATCH,  BR_JUMP,  S_EMIT};
      default:  word = '{MUL_IDLE,       CAP_NONE,   BR_END,   S_SUM};
    endcase
  end

  assign s_tready = !busy && !rst;
  assign stall    = (word.cap == CAP_EMIT) && m_tvalid && !m_tready;
  assign run      = busy && !stall;

  assign ctl.load = s_tvalid && !busy;
  assign ctl.mul  = word.mul;
  assign ctl.cap  = run ? word.cap : CAP_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pc       <= S_SUM;
      m_tvalid <= 1'b0;
    end else begin
      if (run && (word.cap == CAP_EMIT)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (!busy) begin
        if (s_tvalid) begin
          busy <= 1'b1;
          pc   <= S_SUM;
        end
      end else if (run) begin
        case (word.br)
          BR_NEXT:  pc <= pc + 4'd1;
          BR_LATCH: pc <= st.latch ? word.target : pc + 4'd1;
          BR_ITER:  pc <= st.iter_last ? pc + 4'd1 : word.target;
          BR_JUMP:  pc <= word.target;
          BR_END:   busy <= 1'b0;
          default:  busy <= 1'b0;
        endcase
      end
    end
  end

endmodule

// ----- rtl/ddo_datapath.sv -----
// Multiplier, CORDIC rotator, pose registers and result register of the odometry block.
`timescale 1ns / 1ps
module ddo_datapath #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  ddo_pkg::ctl_t    ctl,
  output ddo_pkg::status_t st,
  input  logic             s_tuser,
  input  logic [31:0]      s_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  output logic [191:0]     m_tdata
);
  import ddo_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);

  logic               mode;
  logic [15:0]        left_delta;
  logic [15:0]        right_delta;
  logic [31:0]        distance_per_count;
  logic [31:0]        heading_gain;

  logic [31:0]        cur_x, cur_y, cur_heading;
  logic [31:0]        origin_x, origin_y, origin_heading;

  logic [16:0]        sum17, dif17;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic [31:0]        disp;
  logic [48:0]        dif_w;
  logic [31:0]        dth;
  logic signed [49:0] vx, vy, sx, sy, tx, ty, rx, ry;
  logic [31:0]        z;
  logic [1:0]         quad;
  logic [IW-1:0]      iter;

  logic [49:0]        disp_sum;
  logic [64:0]        dth_sum;
  logic [31:0]        hq;
  logic [1:0]         q_new;

  assign st.latch     = mode;
  assign st.iter_last = (iter == ITER_LAST);

  assign sum17 = {left_delta[15], left_delta} + {right_delta[15], right_delta};
  assign dif17 = {right_delta[15], right_delta} - {left_delta[15], left_delta};

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl.mul)
      MUL_SUM_DPC: begin
        ma = $signed({{16{sum17[16]}}, sum17});
        mb = $signed({1'b0, distance_per_count});
      end
      MUL_DIF_DPC: begin
        ma = $signed({{16{dif17[16]}}, dif17});
        mb = $signed({1'b0, distance_per_count});
      end
      MUL_DISP_K: begin
        ma = $signed({disp[31], disp});
        mb = $signed({1'b0, CORDIC_GAIN});
      end
      MUL_DIFLO_GAIN: begin
        ma = $signed({1'b0, dif_w[31:0]});
        mb = $signed({1'b0, heading_gain});
      end
      MUL_DIFHI_GAIN: begin
        ma = $signed({{16{dif_w[48]}}, dif_w[48:32]});
        mb = $signed({1'b0, heading_gain});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign disp_sum = {prod[48], prod[48:0]} + 50'h10000;
  assign dth_sum  = {1'b0, prod[63:0]} + 65'h80000000;
  assign hq       = cur_heading + 32'h20000000;
  assign q_new    = hq[31:30];

  assign sx = vx >>> iter;
  assign sy = vy >>> iter;

  always_comb begin
    case (quad)
      2'd1: begin
        tx = -vy;
        ty = vx;
      end
      2'd2: begin
        tx = -vx;
        ty = -vy;
      end
      2'd3: begin
        tx = vy;
        ty = -vx;
      end
      default: begin
        tx = vx;
        ty = vy;
      end
    endcase
  end

  assign rx = tx + 50'sd32768;
  assign ry = ty + 50'sd32768;

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (ctl.load) begin
      mode        <= s_tuser;
      left_delta  <= s_tdata[15:0];
      right_delta <= s_tdata[31:16];
    end
    case (ctl.cap)
      CAP_DISP:   disp  <= disp_sum[48:17];
      CAP_DIF:    dif_w <= prod[48:0];
      CAP_VINIT: begin
        vx   <= prod[65:16];
        vy   <= '0;
        quad <= q_new;
        z    <= cur_heading - {q_new, 30'd0};
        iter <= '0;
      end
      CAP_DTH_LO: dth <= dth_sum[63:32];
      CAP_DTH_HI: dth <= dth + prod[31:0];
      CAP_CORDIC: begin
        if (!z[31]) begin
          vx <= vx - sy;
          vy <= vy + sx;
          z  <= z - cordic_atan(5'(iter));
        end else begin
          vx <= vx + sy;
          vy <= vy - sx;
          z  <= z + cordic_atan(5'(iter));
        end
        iter <= iter + 1'b1;
      end
      CAP_EMIT: begin
        m_tdata <= {cur_heading - origin_heading, cur_y - origin_y, cur_x - origin_x,
                    cur_heading, cur_y, cur_x};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_per_count <= '0;
      heading_gain       <= '0;
      cur_x              <= '0;
      cur_y              <= '0;
      cur_heading        <= '0;
      origin_x           <= '0;
      origin_y           <= '0;
      origin_heading     <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index) begin
          heading_gain <= cfg_data;
        end else begin
          distance_per_count <= cfg_data;
        end
      end
      case (ctl.cap)
        CAP_ROTATE: begin
          cur_x       <= cur_x + rx[47:16];
          cur_y       <= cur_y + ry[47:16];
          cur_heading <= cur_heading + dth;
        end
        CAP_LATCH: begin
          origin_x       <= cur_x;
          origin_y       <= cur_y;
          origin_heading <= cur_heading;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/differential_drive_odometry.sv -----
// Top level of the differential-drive dead-reckoning odometry block.
//
// Input stream (s_*): one transfer per encoder sample. s_tuser is the mode:
// 0 applies the left and right count deltas in s_tdata, 1 latches the current
// pose as the start pose. Output stream (m_*): one transfer per input item with
// absolute pose and pose relative to the start pose.
// Configuration (cfg_*): index 0 distance per count, index 1 heading gain;
// cfg_ready is high outside reset; write only while the block is idle.
// Program: a motion item runs through the microcode program, with one
// CORDIC iteration per cycle and the shared 33x33 multiplier used five times.
// A latch item runs only the sum, latch and result steps. s_tready is high
// only while no item is in work, so a new item is taken only once the last
// one has finished its program.
// A finished result waits in the output register; a new item is taken
// meanwhile, and its program holds at the result step until m_tready frees it.
// Reset clears pose, start pose and both registers to zero and drops m_tvalid.
`timescale 1ns / 1ps
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // left_delta[15:0], right_delta[31:16]
  input  logic         s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // pos_x, pos_y, heading, rel_x, rel_y, rel_heading
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import ddo_pkg::*;

  ctl_t    ctl;
  status_t st;

  assign cfg_ready = !rst;

  ddo_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .ctl      (ctl)
  );

  ddo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .st        (st),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- tb/odo_tb_pkg.sv -----
// Register indexes, mode codes and the pose record shared by the odometry testbench.
`timescale 1ns / 1ps
package odo_tb_pkg;

  localparam logic REG_DIST_PER_COUNT = 1'b0;
  localparam logic REG_HEADING_GAIN   = 1'b1;

  localparam logic MODE_MOVE  = 1'b0;
  localparam logic MODE_LATCH = 1'b1;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] rel_x;
    logic [31:0] rel_y;
    logic [31:0] rel_heading;
  } pose_t;

endpackage

// ----- tb/odometry_checker.sv -----
// Pose predictor and result scoreboard that watches the odometry stream and config channels.
`timescale 1ns / 1ps
module odometry_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,   // left_delta[15:0], right_delta[31:16]
  input  logic         s_tuser,   // mode
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [191:0] m_tdata,   // pos_x, pos_y, heading, rel_x, rel_y, rel_heading
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  output int           mismatches,
  output int           outstanding,
  output int           results
);
  import odo_tb_pkg::*;

  localparam logic [63:0] ROTATOR_GAIN = 64'd2608131496;

  localparam logic [0:31][31:0] ATAN_BAM = {
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  logic [31:0] dist_per_count;
  logic [31:0] heading_gain;
  logic [31:0] cur_x, cur_y, cur_heading;
  logic [31:0] start_x, start_y, start_heading;
  pose_t       pose_q[$];

  function automatic void advance_pose(input logic [15:0] left_cnt, input logic [15:0] right_cnt);
    logic [63:0] lw, rw, sum, disp, turn, vx, vy, sx, sy, tx, ty, rx, ry;
    logic [31:0] z, dth;
    logic [1:0]  q;
    int          i;
    lw   = {{48{left_cnt[15]}}, left_cnt} * {32'd0, dist_per_count};
    rw   = {{48{right_cnt[15]}}, right_cnt} * {32'd0, dist_per_count};
    sum  = lw + rw + 64'h1_0000;
    disp = $signed(sum) >>> 17;
    turn = (rw - lw) * {32'd0, heading_gain} + 64'h8000_0000;
    dth  = turn[63:32];
    z    = cur_heading + 32'h2000_0000;
    q    = z[31:30];
    z    = cur_heading - {q, 30'd0};
    vx   = disp * ROTATOR_GAIN;
    vx   = $signed(vx) >>> 16;
    vy   = '0;
    for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      sx = $signed(vx) >>> i;
      sy = $signed(vy) >>> i;
      if (!z[31]) begin
        vx = vx - sy;
        vy = vy + sx;
        z  = z - ATAN_BAM[i];
      end else begin
        vx = vx + sy;
        vy = vy - sx;
        z  = z + ATAN_BAM[i];
      end
    end
    case (q)
      2'd1: begin
        tx = -vy;
        ty = vx;
      end
      2'd2: begin
        tx = -vx;
        ty = -vy;
      end
      2'd3: begin
        tx = vy;
        ty = -vx;
      end
      default: begin
        tx = vx;
        ty = vy;
      end
    endcase
    rx = tx + 64'h8000;
    ry = ty + 64'h8000;
    rx = $signed(rx) >>> 16;
    ry = $signed(ry) >>> 16;
    cur_x       = cur_x + rx[31:0];
    cur_y       = cur_y + ry[31:0];
    cur_heading = cur_heading + dth;
  endfunction

  function automatic pose_t odometry_step(input logic mode, input logic [31:0] deltas);
    pose_t p;
    if (mode == MODE_LATCH) begin
      start_x       = cur_x;
      start_y       = cur_y;
      start_heading = cur_heading;
    end else begin
      advance_pose(deltas[15:0], deltas[31:16]);
    end
    p.pos_x       = cur_x;
    p.pos_y       = cur_y;
    p.heading     = cur_heading;
    p.rel_x       = cur_x - start_x;
    p.rel_y       = cur_y - start_y;
    p.rel_heading = cur_heading - start_heading;
    return p;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pose_t want;
    pose_t got;
    if (rst) begin
      dist_per_count = '0;
      heading_gain   = '0;
      cur_x          = '0;
      cur_y          = '0;
      cur_heading    = '0;
      start_x        = '0;
      start_y        = '0;
      start_heading  = '0;
      pose_q.delete();
      mismatches     = 0;
      results        = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DIST_PER_COUNT) dist_per_count = cfg_data;
        else heading_gain = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        results++;
        got.pos_x       = m_tdata[31:0];
        got.pos_y       = m_tdata[63:32];
        got.heading     = m_tdata[95:64];
        got.rel_x       = m_tdata[127:96];
        got.rel_y       = m_tdata[159:128];
        got.rel_heading = m_tdata[191:160];
        if (pose_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing pending, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = pose_q.pop_front();
          check_field("pos_x", want.pos_x, got.pos_x);
          check_field("pos_y", want.pos_y, got.pos_y);
          check_field("heading", want.heading, got.heading);
          check_field("rel_x", want.rel_x, got.rel_x);
          check_field("rel_y", want.rel_y, got.rel_y);
          check_field("rel_heading", want.rel_heading, got.rel_heading);
        end
      end
      if (s_tvalid && s_tready) pose_q.push_back(odometry_step(s_tuser, s_tdata));
    end
    outstanding = pose_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Stimulus, receiver backpressure and verdict for the odometry block testbench.
`timescale 1ns / 1ps
module testbench;
  import odo_tb_pkg::*;

  localparam int CORDIC_STEPS = 24;
  localparam int DRAIN_CYCLES = CORDIC_STEPS + 12;

  typedef enum logic [1:0] {
    STALL_NONE = 2'd0,
    STALL_COIN = 2'd1,
    STALL_LONG = 2'd2
  } stall_t;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata   = '0;
  logic         s_tuser   = MODE_MOVE;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [191:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = REG_DIST_PER_COUNT;
  logic [31:0]  cfg_data  = '0;

  int     mismatches;
  int     outstanding;
  int     results;
  int     items_sent   = 0;
  int     latches_sent = 0;
  int     reg_settings = 0;
  int     hold_cnt     = 0;
  stall_t stall_mode   = STALL_NONE;

  always #5 clk = ~clk;

  differential_drive_odometry #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  odometry_checker #(.CORDIC_STEPS(CORDIC_STEPS)) checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .results(results)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      case (stall_mode)
        STALL_NONE: m_tready <= 1'b1;
        STALL_COIN: m_tready <= 1'($urandom_range(0, 1));
        default: begin
          m_tready <= 1'b1;
          hold_cnt <= $urandom_range(0, 40);
        end
      endcase
    end
  end

  task automatic send_item(input logic mode, input logic [15:0] left, input logic [15:0] right);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {right, left};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    items_sent++;
    if (mode == MODE_LATCH) latches_sent++;
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] dpc, input logic [31:0] gain);
    write_reg(REG_DIST_PER_COUNT, dpc);
    write_reg(REG_HEADING_GAIN, gain);
    cfg_valid <= 1'b0;
    reg_settings++;
  endtask

  function automatic logic [15:0] pick_delta();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) return 16'($urandom_range(0, 400)) - 16'd200;
    if (kind < 85) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic random_item();
    logic [15:0] left;
    logic [15:0] right;
    left  = pick_delta();
    right = ($urandom_range(0, 9) == 0) ? left : pick_delta();
    if ($urandom_range(0, 99) < 8) send_item(MODE_LATCH, left, right);
    else send_item(MODE_MOVE, left, right);
  endtask

  task automatic run_phase(input logic [31:0] dpc, input logic [31:0] gain,
                           input int count, input int max_gap, input logic busy_rx);
    int sent;
    int burst;
    drain();
    set_regs(dpc, gain);
    stall_mode <= busy_rx ? stall_t'($urandom_range(0, 2)) : STALL_NONE;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        random_item();
        sent++;
      end
      if (busy_rx && $urandom_range(0, 3) == 0) stall_mode <= stall_t'($urandom_range(0, 2));
      if (max_gap > 0) idle($urandom_range(0, max_gap));
    end
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset: pose holds
    send_item(MODE_MOVE, 16'd1000, -16'sd1000);
    send_item(MODE_MOVE, 16'h7FFF, 16'h8000);
    send_item(MODE_LATCH, 16'h1234, 16'hFEDC);
    drain();

    set_regs(32'd4194304, 32'd2278555648);
    stall_mode <= STALL_COIN;
    send_item(MODE_MOVE, 16'h7FFF, 16'h7FFF);
    send_item(MODE_MOVE, 16'h8000, 16'h8000);
    send_item(MODE_MOVE, 16'h8000, 16'h7FFF);
    send_item(MODE_MOVE, 16'h7FFF, 16'h8000);
    idle(3);
    send_item(MODE_MOVE, 16'h0000, 16'h0000);
    send_item(MODE_LATCH, 16'hFFFF, 16'h7FFF);
    send_item(MODE_MOVE, 16'd100, 16'd300);
    send_item(MODE_MOVE, 16'hFFFF, 16'h0001);
    send_item(MODE_MOVE, 16'd2000, 16'd2000);
    send_item(MODE_LATCH, 16'h0000, 16'h0000);
    drain();

    // wrap positions and heading
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    stall_mode <= STALL_LONG;
    send_item(MODE_MOVE, 16'h7FFF, 16'h7FFF);
    send_item(MODE_MOVE, 16'h7FFF, 16'h7FFF);
    send_item(MODE_MOVE, 16'h8000, 16'h7FFF);
    send_item(MODE_MOVE, 16'h7FFF, 16'h7FFF);
    send_item(MODE_MOVE, 16'h7FFF, 16'h8000);
    send_item(MODE_MOVE, 16'h8000, 16'h8000);
    send_item(MODE_LATCH, 16'h5555, 16'hAAAA);
    send_item(MODE_MOVE, 16'h7FFF, 16'h7FFF);

    run_phase(32'd429497, 32'd2278555648, 100, 15, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 15, 1'b1);
    run_phase($urandom, $urandom, 100, 15, 1'b1);
    run_phase($urandom, 32'd0, 100, 15, 1'b1);
    run_phase(32'd0, $urandom, 100, 15, 1'b1);
    run_phase(32'd4194304, $urandom, 100, 15, 1'b1);
    run_phase($urandom_range(1, 1 << 20), $urandom, 100, 15, 1'b1);
    run_phase($urandom, $urandom, 100, 0, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d start-pose latches) over %0d register settings",
             items_sent, latches_sent, reg_settings);
    $display("checked %0d results, %0d field mismatches", results, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
